@@ rtl/pixel_frame_threshold_packer_unit_assert.svh @@
// Assertion macros for the pixel frame threshold packer.
// Depends on nothing; included by pftp_pack_core, the module that carries checks.
`ifndef PIXEL_FRAME_THRESHOLD_PACKER_UNIT_ASSERT_SVH
`define PIXEL_FRAME_THRESHOLD_PACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PFTP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pftp same-cycle check failed");
`define PFTP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pftp next-cycle check failed");
`else
`define PFTP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PFTP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/pftp_pkg.sv @@
// Shared constants and types for the pixel frame threshold packer.
// No dependencies; imported by both modules and the testbench.
package pftp_pkg;

  localparam int unsigned FRAME_WIDTH  = 18;
  localparam int unsigned FRAME_HEIGHT = 18;
  localparam int unsigned FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned PIX_CNT_W    = $clog2(FRAME_PIXELS + 1);

  localparam int unsigned SOF_POS   = 7;
  localparam int unsigned VALID_POS = 6;
  localparam int unsigned VALUE_W   = 6;

  localparam logic [7:0] THRESHOLD_RESET = 8'd64;

  // Result of one processed transaction
  typedef struct packed {
    logic       emit;
    logic [7:0] packed_byte;
    logic       frame_last;
  } pftp_result_t;

endpackage

@@ rtl/pftp_pix_if.sv @@
// Input channel carrying raw sensor dump bytes.
// Depends on nothing beyond plain logic types.
interface pftp_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_register;

  modport source (output valid, output pixel_register, input ready);
  modport sink   (input valid, input pixel_register, output ready);
endinterface

@@ rtl/pftp_byte_if.sv @@
// Output channel carrying packed threshold bytes.
// Depends on nothing beyond plain logic types.
interface pftp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       frame_last;

  modport source (output valid, output packed_byte, output frame_last, input ready);
  modport sink   (input valid, input packed_byte, input frame_last, output ready);
endinterface

@@ rtl/pixel_frame_threshold_packer_unit.sv @@
// Top level of the pixel frame threshold packer: input register, core, result register.
// Depends on pftp_pkg, pftp_pix_if, pftp_byte_if and pftp_pack_core.
//
// Usage:
//   pix_i carries raw sensor dump bytes (bit7 start of frame, bit6 valid,
//   bits5..0 pixel value). byte_o carries packed bytes of eight threshold
//   bits, earliest pixel in the highest filled bit, with frame_last set on
//   the final, possibly partial, byte of each frame. cfg_we_i/cfg_wdata_i
//   write the threshold; write it only while no transaction is in flight.
//   Throughput: one input transaction per cycle, sustained while the receiver keeps
//   up, set by the single compare-and-shift step between the input register and
//   the result register. An accepted byte is held in the input register; its packed
//   byte, when one completes, is then loaded into the result register.
//   Reset clears the frame state to hunting for a start-of-frame byte, empties
//   both registers and sets the threshold to 64.
//   When the receiver stalls, the result register holds its transaction, the
//   input register holds one more byte, and pix_i.ready drops until a slot frees.
module pixel_frame_threshold_packer_unit import pftp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  pftp_pix_if.sink    pix_i,
  pftp_byte_if.source byte_o
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  logic [7:0]   out_byte_q;
  logic         out_last_q;
  logic [7:0]   threshold_q;
  logic         out_free;
  logic         step;
  pftp_result_t result;

  // Move the held byte forward whenever the result register can take a result
  assign out_free    = !out_valid_q || byte_o.ready;
  assign step        = in_valid_q && out_free;
  assign pix_i.ready = !in_valid_q || out_free;

  // Hold the threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  // Capture input transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      in_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      in_byte_q <= pix_i.pixel_register;
    end
  end

  pftp_pack_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .raw_i      (in_byte_q),
    .threshold_i(threshold_q),
    .result_o   (result)
  );

  // Load results, drop them once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= result.emit;
    end else if (byte_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && result.emit) begin
      out_byte_q <= result.packed_byte;
      out_last_q <= result.frame_last;
    end
  end

  assign byte_o.valid       = out_valid_q;
  assign byte_o.packed_byte = out_byte_q;
  assign byte_o.frame_last  = out_last_q;

endmodule

@@ rtl/pftp_pack_core.sv @@
// Frame tracking, threshold compare and bit packing state for one byte per cycle while step_i is high.
// Depends on pftp_pkg and the assertion macro header.
`include "pixel_frame_threshold_packer_unit_assert.svh"

module pftp_pack_core import pftp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         raw_i,
  input  logic [7:0]         threshold_i,
  output pftp_result_t       result_o
);

  logic                 hunting_q, hunting_d;
  logic [PIX_CNT_W-1:0] pix_cnt_q, pix_cnt_d;
  logic [2:0]           bit_cnt_q, bit_cnt_d;
  logic [7:0]           shift_q, shift_d;

  logic                 active;
  logic                 is_pixel;
  logic                 pix_bit;
  logic [7:0]           shift_new;
  logic [PIX_CNT_W-1:0] pix_cnt_inc;
  logic                 done;
  logic                 emit;

  // Decode the byte and compare the pixel value with the threshold
  assign active      = !hunting_q || raw_i[SOF_POS];
  assign is_pixel    = active && raw_i[VALID_POS];
  assign pix_bit     = {2'b00, raw_i[VALUE_W-1:0]} > threshold_i;
  assign shift_new   = {shift_q[6:0], pix_bit};
  assign pix_cnt_inc = pix_cnt_q + 1'b1;
  assign done        = pix_cnt_inc == PIX_CNT_W'(FRAME_PIXELS);
  assign emit        = is_pixel && ((bit_cnt_q == 3'd7) || done);

  assign result_o.emit        = step_i && emit;
  assign result_o.packed_byte = shift_new;
  assign result_o.frame_last  = done;

  // Advance frame state; counters are already clear while hunting
  always_comb begin
    hunting_d = hunting_q;
    pix_cnt_d = pix_cnt_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    if (step_i && active) begin
      hunting_d = 1'b0;
      if (is_pixel) begin
        shift_d   = emit ? 8'd0 : shift_new;
        bit_cnt_d = emit ? 3'd0 : bit_cnt_q + 3'd1;
        pix_cnt_d = done ? '0 : pix_cnt_inc;
        hunting_d = done;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunting_q <= 1'b1;
      pix_cnt_q <= '0;
      bit_cnt_q <= 3'd0;
      shift_q   <= 8'd0;
    end else begin
      hunting_q <= hunting_d;
      pix_cnt_q <= pix_cnt_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
    end
  end

  `PFTP_ASSERT_IMP(a_hunt_clear, clk_i, rst_ni, hunting_q,
                   (pix_cnt_q == '0) && (bit_cnt_q == 3'd0) && (shift_q == 8'd0))
  `PFTP_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, pix_cnt_q < PIX_CNT_W'(FRAME_PIXELS))
  `PFTP_ASSERT_NXT(a_last_hunts, clk_i, rst_ni, result_o.emit && result_o.frame_last,
                   hunting_q)

endmodule

@@ tb/tb_pixel_frame_threshold_packer_unit.sv @@
// Self-checking testbench for pixel_frame_threshold_packer_unit: random and directed dump bytes,
// a built-in packer model predicting every packed byte, and random stalls on both channels.
// Depends on pftp_pkg, pftp_pix_if, pftp_byte_if and the packer RTL.
module tb_pixel_frame_threshold_packer_unit;
  import pftp_pkg::*;

  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 98;
  localparam int unsigned LONG_HOLD       = 200;
  localparam int unsigned DRAIN_PAD       = 4;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  typedef struct {
    logic [7:0] pbyte;
    logic       last;
  } packed_exp_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  pftp_pix_if  pix_bus ();
  pftp_byte_if pkd_bus ();

  pixel_frame_threshold_packer_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix_bus),
    .byte_o      (pkd_bus)
  );

  // Packer model state
  logic              hunt_st;
  int unsigned       pix_cnt;
  int unsigned       bit_cnt;
  logic [7:0]        shift_reg;
  logic [7:0]        thresh;

  logic [7:0]  pixel_q [$];
  packed_exp_t packed_q [$];

  packed_exp_t want;
  logic        idle_en;
  int unsigned gap_cnt;
  int unsigned stall_cnt;
  int unsigned hold_cnt;
  logic        hold_done;
  int unsigned err_cnt;
  int unsigned cyc;
  int unsigned ph;
  logic [7:0]  phase_thresh;
  logic [7:0]  thresh_plan [NUM_PHASES];

  // Advance the packer model by one accepted dump byte
  function automatic void pack_pixel(input logic [7:0] raw);
    packed_exp_t res;
    logic        frame_done;
    if (hunt_st) begin
      if (!raw[SOF_POS]) return;
      hunt_st   = 1'b0;
      pix_cnt   = 0;
      bit_cnt   = 0;
      shift_reg = '0;
    end
    if (!raw[VALID_POS]) return;
    shift_reg  = {shift_reg[6:0], ({2'b00, raw[VALUE_W-1:0]} > thresh)};
    bit_cnt++;
    pix_cnt++;
    frame_done = (pix_cnt >= FRAME_PIXELS);
    if (bit_cnt < 8 && !frame_done) return;
    res.pbyte = shift_reg;
    res.last  = frame_done;
    packed_q.push_back(res);
    bit_cnt   = 0;
    shift_reg = '0;
    if (frame_done) begin
      hunt_st = 1'b1;
      pix_cnt = 0;
    end
  endfunction

  // Mostly valid pixels, some near the threshold, some invalid bytes and raw noise
  function automatic logic [7:0] rand_pixel();
    int unsigned sel;
    int          tv;
    logic [5:0]  val;
    logic        sof;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 8'($urandom);
    val = 6'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      tv = int'(thresh) + int'($urandom_range(0, 2)) - 1;
      if (tv < 0) tv = 0;
      if (tv > 63) tv = 63;
      val = 6'(tv);
    end
    sof = ($urandom_range(0, 9) == 0);
    return {sof, (sel < 88), val};
  endfunction

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  // Wait until no transaction is pending, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk);
    while (pixel_q.size() != 0 || pix_bus.valid || packed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thresh     = v;
  endtask

  always #5 clk = ~clk;

  // Run timeout
  always @(posedge clk) begin
    cyc++;
    if (cyc >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drive dump bytes from the pending queue, with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_bus.valid <= 1'b0;
      gap_cnt       <= 0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) pack_pixel(pix_bus.pixel_register);
      if (!pix_bus.valid || pix_bus.ready) begin
        if (gap_cnt > 0) begin
          gap_cnt       <= gap_cnt - 1;
          pix_bus.valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          pix_bus.valid          <= 1'b1;
          pix_bus.pixel_register <= pixel_q.pop_front();
          if (idle_en && $urandom_range(0, 4) == 0) gap_cnt <= $urandom_range(1, 8);
        end else begin
          pix_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Drive ready: one long hold-off while the sender has plenty queued, then random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      pkd_bus.ready <= 1'b0;
      stall_cnt     <= 0;
      hold_cnt      <= 0;
      hold_done     <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt      <= hold_cnt - 1;
      pkd_bus.ready <= 1'b0;
    end else if (!hold_done && pixel_q.size() > 40) begin
      hold_done     <= 1'b1;
      hold_cnt      <= LONG_HOLD - 1;
      pkd_bus.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt     <= stall_cnt - 1;
      pkd_bus.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_cnt     <= $urandom_range(0, 7);
      pkd_bus.ready <= 1'b0;
    end else begin
      pkd_bus.ready <= 1'b1;
    end
  end

  // Check each packed byte against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && pkd_bus.valid && pkd_bus.ready) begin
      if (packed_q.size() == 0) begin
        note_error($sformatf("unexpected packed byte %02h last %0b",
                             pkd_bus.packed_byte, pkd_bus.frame_last));
      end else begin
        want = packed_q.pop_front();
        if (pkd_bus.packed_byte !== want.pbyte || pkd_bus.frame_last !== want.last)
          note_error($sformatf("packed byte mismatch: expected %02h last %0b, got %02h last %0b",
                               want.pbyte, want.last, pkd_bus.packed_byte, pkd_bus.frame_last));
      end
    end
  end

  initial begin
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    pix_bus.valid          = 1'b0;
    pix_bus.pixel_register = '0;
    pkd_bus.ready          = 1'b0;
    idle_en                = 1'b1;
    err_cnt                = 0;
    cyc                    = 0;
    hunt_st                = 1'b1;
    pix_cnt                = 0;
    bit_cnt                = 0;
    shift_reg              = '0;
    thresh                 = THRESHOLD_RESET;
    thresh_plan            = '{8'd0, 8'd255, 8'd63, 8'd31, 8'd1, 8'd0, 8'd0, 8'd62};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset threshold: noise while hunting, a start byte without the valid bit,
    // start bits inside the frame, invalid bytes skipped, values at both ends
    @(negedge clk);
    pixel_q = '{8'h00, 8'h7F, 8'h40, 8'h80, 8'hC0, 8'h7F, 8'h3F, 8'hFF,
                8'h41, 8'h60, 8'h4A, 8'h7E, 8'h55, 8'h6B};
    wait_drained();

    // Change the threshold in the middle of a byte and a frame
    write_threshold(8'd0);
    @(negedge clk);
    pixel_q = '{8'h40, 8'h41, 8'h7F, 8'hC1, 8'h01, 8'h60, 8'h5F, 8'h42};
    wait_drained();

    // Random phases, each under its own threshold; no idling in the last one
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      phase_thresh = (ph == 5 || ph == 6) ? 8'($urandom) : thresh_plan[ph];
      write_threshold(phase_thresh);
      @(negedge clk);
      if (ph == NUM_PHASES - 1) idle_en = 1'b0;
      repeat (ITEMS_PER_PHASE) pixel_q.push_back(rand_pixel());
      wait_drained();
    end

    if (err_cnt == 0 && packed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
